/* hdl/point_in_polygon_test_defines.svh */
// ----------------------------------------------------------------------------
// Point in polygon test: assertion macros
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// antecedent and consequent in the same cycle
`define PIP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent in the cycle after the antecedent
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/pip_pkg.sv */
// ----------------------------------------------------------------------------
// Point in polygon test: package
// Word kind codes and the token and control structs of the cell row.
// ----------------------------------------------------------------------------
package pip_pkg;

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_QUERY = 1'b1
   } pip_kind_type;

   // query token handed from cell to cell
   typedef struct packed {
      logic valid;
      logic parity;
   } pip_tok_type;

   // per-cell setting derived from the vertex count
   typedef struct packed {
      logic active;
      logic wrap;
   } pip_ctl_type;

endpackage

/* hdl/point_in_polygon_test.sv */
// ----------------------------------------------------------------------------
// Point in polygon test: top level
// Even-odd crossing test of a point against a polygon held in a row of cells.
// ----------------------------------------------------------------------------
// A write word stores one vertex in its cell. A query word enters a row of
// MAX_VERTICES cells, one cell per cycle while the row is not held, each
// cell testing the edge from its vertex to the next (the last vertex in use
// closes back to vertex 0). The row holds one query at a time and the input
// stalls until the answer leaves the row. A stalled answer holds the row.
// The vertex count register is to be written only while idle; the block
// itself does not enforce this. Vertices not yet written give an undefined
// answer.
module point_in_polygon_test #(
   parameter int MAX_VERTICES = 16,
   parameter int COORD_BITS   = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [4:0]                   csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_kind,
   input  logic [3:0]                   req_vertex_index,
   input  logic signed [COORD_BITS-1:0] req_vertex_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_y,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_inside_res
);

   localparam int NW = $clog2(MAX_VERTICES + 1);

   logic [4:0]           vertex_count_ff, vertex_count_in;
   logic [NW-1:0]        n_eff;
   logic                 busy_ff, busy_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_inside_ff, rsp_inside_in;
   logic                 accept, is_query, advance, load;

   pip_pkg::pip_tok_type         tok [MAX_VERTICES+1];
   logic signed [COORD_BITS-1:0] px  [MAX_VERTICES+1];
   logic signed [COORD_BITS-1:0] py  [MAX_VERTICES+1];
   logic signed [COORD_BITS-1:0] vx  [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] vy  [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] nbx [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] nby [MAX_VERTICES];

   assign accept   = req_valid && !req_stall;
   assign is_query = req_kind == pip_pkg::KIND_QUERY;
   assign advance  = !(tok[MAX_VERTICES].valid && rsp_valid_ff && rsp_stall);
   assign load     = tok[MAX_VERTICES].valid && advance;

   always_comb begin
      if (32'(vertex_count_ff) > MAX_VERTICES) begin
         n_eff = NW'(MAX_VERTICES);
      end else begin
         n_eff = NW'(vertex_count_ff);
      end
   end

   assign tok[0].valid  = accept && is_query;
   assign tok[0].parity = 1'b0;
   assign px[0]         = req_point_x;
   assign py[0]         = req_point_y;

   for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
      pip_pkg::pip_ctl_type ctl;
      logic                 wr_en;

      assign ctl.active = 32'(n_eff) > k;
      assign ctl.wrap   = 32'(n_eff) == k + 1;
      assign wr_en      = accept && !is_query && (32'(req_vertex_index) == k);

      if (k == MAX_VERTICES - 1) begin : g_last
         assign nbx[k] = vx[0];
         assign nby[k] = vy[0];
      end else begin : g_mid
         assign nbx[k] = vx[k+1];
         assign nby[k] = vy[k+1];
      end

      pip_cell #(
         .COORD_BITS(COORD_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .wr_en   (wr_en),
         .wr_x    (req_vertex_x),
         .wr_y    (req_vertex_y),
         .ctl     (ctl),
         .nb_x    (nbx[k]),
         .nb_y    (nby[k]),
         .first_x (vx[0]),
         .first_y (vy[0]),
         .tok_i   (tok[k]),
         .px_i    (px[k]),
         .py_i    (py[k]),
         .vx      (vx[k]),
         .vy      (vy[k]),
         .tok_o   (tok[k+1]),
         .px_o    (px[k+1]),
         .py_o    (py[k+1])
      );
   end

   always_comb begin
      vertex_count_in = csr_wr_en ? csr_wr_data : vertex_count_ff;
      busy_in         = busy_ff;
      if (accept && is_query) begin
         busy_in = 1'b1;
      end else if (load) begin
         busy_in = 1'b0;
      end
      rsp_valid_in  = rsp_valid_ff;
      rsp_inside_in = rsp_inside_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_inside_in = tok[MAX_VERTICES].parity;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_inside_ff <= rsp_inside_in;
      if (reset) begin
         vertex_count_ff <= '0;
         busy_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         vertex_count_ff <= vertex_count_in;
         busy_ff         <= busy_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign req_stall      = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

endmodule

/* hdl/pip_cell.sv */
// ----------------------------------------------------------------------------
// Point in polygon test: vertex cell
// Holds one vertex and tests the edge to the next vertex against the query
// token passing through, toggling the inside bit on a crossing.
// ----------------------------------------------------------------------------
module pip_cell #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         wr_en,
   input  logic signed [COORD_BITS-1:0] wr_x,
   input  logic signed [COORD_BITS-1:0] wr_y,
   input  pip_pkg::pip_ctl_type         ctl,
   input  logic signed [COORD_BITS-1:0] nb_x,
   input  logic signed [COORD_BITS-1:0] nb_y,
   input  logic signed [COORD_BITS-1:0] first_x,
   input  logic signed [COORD_BITS-1:0] first_y,
   input  pip_pkg::pip_tok_type         tok_i,
   input  logic signed [COORD_BITS-1:0] px_i,
   input  logic signed [COORD_BITS-1:0] py_i,
   output logic signed [COORD_BITS-1:0] vx,
   output logic signed [COORD_BITS-1:0] vy,
   output pip_pkg::pip_tok_type         tok_o,
   output logic signed [COORD_BITS-1:0] px_o,
   output logic signed [COORD_BITS-1:0] py_o
);

   localparam int D = COORD_BITS + 1;
   localparam int P = 2 * D;

   logic signed [COORD_BITS-1:0] vx_ff, vy_ff, vx_in, vy_in;
   logic signed [COORD_BITS-1:0] xj, yj;
   logic signed [D-1:0]          dy, ax, bx, ay;
   logic signed [P-1:0]          pa, pb;
   logic                         straddle, left, toggle;
   pip_pkg::pip_tok_type         tok_ff, tok_in;
   logic signed [COORD_BITS-1:0] px_ff, py_ff, px_in, py_in;

   assign xj = ctl.wrap ? first_x : nb_x;
   assign yj = ctl.wrap ? first_y : nb_y;

   assign dy = {yj[COORD_BITS-1], yj} - {vy_ff[COORD_BITS-1], vy_ff};
   assign ax = {px_i[COORD_BITS-1], px_i} - {vx_ff[COORD_BITS-1], vx_ff};
   assign bx = {xj[COORD_BITS-1], xj} - {vx_ff[COORD_BITS-1], vx_ff};
   assign ay = {py_i[COORD_BITS-1], py_i} - {vy_ff[COORD_BITS-1], vy_ff};

   assign pa = P'(ax) * P'(dy);
   assign pb = P'(bx) * P'(ay);

   assign straddle = (vy_ff > py_i) != (yj > py_i);
   assign left     = (!dy[D-1] && (dy != '0)) ? (pa < pb) : (pb < pa);
   assign toggle   = ctl.active && straddle && left;

   always_comb begin
      vx_in = vx_ff;
      vy_in = vy_ff;
      if (wr_en) begin
         vx_in = wr_x;
         vy_in = wr_y;
      end
   end

   always_comb begin
      tok_in = tok_ff;
      px_in  = px_ff;
      py_in  = py_ff;
      if (advance) begin
         tok_in.valid  = tok_i.valid;
         tok_in.parity = tok_i.parity ^ toggle;
         px_in         = px_i;
         py_in         = py_i;
      end
   end

   always_ff @(posedge clock) begin
      vx_ff <= vx_in;
      vy_ff <= vy_in;
      px_ff <= px_in;
      py_ff <= py_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign vx    = vx_ff;
   assign vy    = vy_ff;
   assign tok_o = tok_ff;
   assign px_o  = px_ff;
   assign py_o  = py_ff;

endmodule

/* hdl/pip_checker.sv */
// ----------------------------------------------------------------------------
// Point in polygon test: port checker
// Watches the word handshakes of the top level; bound to it below.
// ----------------------------------------------------------------------------
`include "point_in_polygon_test_defines.svh"

module pip_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_kind,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_inside_res
);

   `PIP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_inside_res), "result word dropped or changed while stalled")

   `PIP_ASSERT_NEXT(a_query_blocks, req_valid && !req_stall && req_kind == pip_pkg::KIND_QUERY, req_stall, "query taken without blocking the input")

   `PIP_ASSERT_NEXT(a_write_silent, req_valid && !req_stall && req_kind == pip_pkg::KIND_WRITE && !rsp_valid, !rsp_valid, "vertex write produced a result")

   `PIP_ASSERT_SAME(a_rsp_from_query, $rose(rsp_valid), $past(req_stall), "result without a query in flight")

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_kind       (req_kind),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_inside_res (rsp_inside_res)
);

/* tb/sv/point_in_polygon_test_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point in polygon test: testbench
// Loads vertex tables and fires point queries through the request channel.
// Each accepted write updates a local copy of the polygon. Each query gives
// an expected even-odd answer, and the answers are checked in order on the
// response channel. The vertex count is changed only between phases, with
// the block idle. Idle and stall rates on both sides change across phases.
// ----------------------------------------------------------------------------
module point_in_polygon_test_tb;

   localparam int MAX_VERTICES  = 16;
   localparam int COORD_BITS    = 16;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct {
      pip_pkg::pip_kind_type        kind;
      logic [3:0]                   slot;
      logic signed [COORD_BITS-1:0] vx;
      logic signed [COORD_BITS-1:0] vy;
      logic signed [COORD_BITS-1:0] px;
      logic signed [COORD_BITS-1:0] py;
   } polygon_word_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_wr_en = 1'b0;
   logic [4:0]                    csr_wr_data = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_kind = 1'b0;
   logic [3:0]                    req_vertex_index = '0;
   logic signed [COORD_BITS-1:0]  req_vertex_x = '0;
   logic signed [COORD_BITS-1:0]  req_vertex_y = '0;
   logic signed [COORD_BITS-1:0]  req_point_x = '0;
   logic signed [COORD_BITS-1:0]  req_point_y = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_inside_res;

   // local copy of the polygon
   logic signed [COORD_BITS-1:0]  poly_x [MAX_VERTICES];
   logic signed [COORD_BITS-1:0]  poly_y [MAX_VERTICES];
   logic [4:0]                    poly_count = '0;

   polygon_word_type              pending_words [$];
   polygon_word_type              cur_word;
   bit                            expected_inside [$];
   bit                            want_inside;
   bit                            word_taken = 1'b0;
   int                            send_idle_pct = 0;
   int                            recv_idle_pct = 0;
   int                            mismatch_count = 0;
   int                            cycle_count = 0;

   point_in_polygon_test #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_vertex_index (req_vertex_index),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_inside_res   (rsp_inside_res)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   function automatic void queue_word(polygon_word_type w);
      pending_words.insert(pending_words.size(), w);
   endfunction

   // even-odd crossing count, exact products in 64 bits
   function automatic bit crossing_parity(logic signed [COORD_BITS-1:0] qx,
                                          logic signed [COORD_BITS-1:0] qy);
      int     n;
      int     j;
      longint px, py, xi, yi, xj, yj, d;
      bit     ins;
      bit     left;
      px = qx;
      py = qy;
      n = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
      ins = 1'b0;
      for (int i = 0; i < n; i++) begin
         j = (i == 0) ? n - 1 : i - 1;
         xi = poly_x[i];
         yi = poly_y[i];
         xj = poly_x[j];
         yj = poly_y[j];
         if ((yi > py) != (yj > py)) begin
            d = yj - yi;
            if (d > 0) begin
               left = (px - xi) * d < (xj - xi) * (py - yi);
            end else begin
               left = (xj - xi) * (py - yi) < (px - xi) * d;
            end
            if (left) begin
               ins = !ins;
            end
         end
      end
      return ins;
   endfunction

   function automatic void absorb_word(polygon_word_type w);
      if (w.kind == pip_pkg::KIND_WRITE) begin
         poly_x[w.slot] = w.vx;
         poly_y[w.slot] = w.vy;
      end else begin
         expected_inside.insert(expected_inside.size(), crossing_parity(w.px, w.py));
      end
   endfunction

   function automatic logic signed [COORD_BITS-1:0] pick_coord(bit tight);
      int r;
      r = $urandom_range(99);
      if (r < 4) return 16'sh8000;
      if (r < 8) return 16'sh7fff;
      if (tight) return 16'(int'($urandom_range(16)) - 8);
      return 16'($urandom);
   endfunction

   function automatic polygon_word_type make_write(int slot,
                                                   logic signed [COORD_BITS-1:0] x,
                                                   logic signed [COORD_BITS-1:0] y);
      polygon_word_type w;
      w.kind = pip_pkg::KIND_WRITE;
      w.slot = 4'(slot);
      w.vx = x;
      w.vy = y;
      w.px = 16'($urandom);
      w.py = 16'($urandom);
      return w;
   endfunction

   function automatic polygon_word_type make_query(logic signed [COORD_BITS-1:0] x,
                                                   logic signed [COORD_BITS-1:0] y);
      polygon_word_type w;
      w.kind = pip_pkg::KIND_QUERY;
      w.slot = 4'($urandom);
      w.vx = 16'($urandom);
      w.vy = 16'($urandom);
      w.px = x;
      w.py = y;
      return w;
   endfunction

   // new polygon first, then mostly queries with the odd vertex rewrite
   task automatic queue_polygon_phase(int used, bit tight, int extra);
      for (int s = 0; s < used && s < MAX_VERTICES; s++) begin
         queue_word(make_write(s, pick_coord(tight), pick_coord(tight)));
      end
      for (int k = 0; k < extra; k++) begin
         if ($urandom_range(99) < 12) begin
            queue_word(make_write($urandom_range(MAX_VERTICES - 1),
                                  pick_coord(tight), pick_coord(tight)));
         end else begin
            queue_word(make_query(pick_coord(tight), pick_coord(tight)));
         end
      end
   endtask

   // idle, then let any trailing write finish
   task automatic drain();
      while (pending_words.size() != 0 || req_valid || expected_inside.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_vertex_count(logic [4:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      poly_count = value;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         word_taken = 1'b1;
         absorb_word(cur_word);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         word_taken = 1'b0;
      end else if (word_taken || !req_valid) begin
         word_taken = 1'b0;
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_word = pending_words.pop_front();
            req_kind <= cur_word.kind;
            req_vertex_index <= cur_word.slot;
            req_vertex_x <= cur_word.vx;
            req_vertex_y <= cur_word.vy;
            req_point_x <= cur_word.px;
            req_point_y <= cur_word.py;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= $urandom_range(99) < recv_idle_pct;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_inside.size() == 0) begin
            report_mismatch("response word with nothing expected");
         end else begin
            want_inside = expected_inside.pop_front();
            if (rsp_inside_res !== want_inside) begin
               report_mismatch($sformatf("inside_res got %b want %b",
                                         rsp_inside_res, want_inside));
            end
         end
      end
   end

   initial begin
      int counts [12] = '{16, 31, 5, 0, 3, 17, 1, 16, 8, 2, 12, 4};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 34;
      recv_idle_pct = 82;

      // count zero after reset, then load all slots, square in the first four
      queue_word(make_query(16'sh8000, 16'sh8000));
      queue_word(make_query(16'sh7fff, 16'sh7fff));
      queue_word(make_write(0, 16'sh8000, 16'sh8000));
      queue_word(make_write(1, 16'sh7fff, 16'sh8000));
      queue_word(make_write(2, 16'sh7fff, 16'sh7fff));
      queue_word(make_write(3, 16'sh8000, 16'sh7fff));
      for (int s = 4; s < MAX_VERTICES; s++) begin
         queue_word(make_write(s, (s % 2) ? 16'sh7fff : 16'sh8000,
                               16'(s * 4369 - 32768)));
      end
      drain();

      set_vertex_count(5'd4);
      queue_word(make_query(16'sd0, 16'sd0));
      queue_word(make_query(16'sh8000, 16'sh8000));
      queue_word(make_query(16'sh7fff, 16'sd0));
      queue_word(make_query(16'sh8000, 16'sd0));
      queue_word(make_query(16'sh7fff, 16'sh7fff));
      queue_word(make_query(16'sd0, 16'sh8000));
      drain();

      for (int p = 0; p < 12; p++) begin
         if (p == 4) begin
            send_idle_pct = 82;
            recv_idle_pct = 34;
         end else if (p == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         set_vertex_count(5'(counts[p]));
         queue_polygon_phase(counts[p], 1'(p % 2), 94);
         drain();
      end

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
